// ===== hdl/tuq_pkg.sv =====
// ----------------------------------------------------------------------------
// tuq_pkg
// Shared types and constants of the timed update queue with linear ramps.
// ----------------------------------------------------------------------------
package tuq_pkg;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_TICK   = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  localparam logic [19:0] FREQ_MIN   = 20'd1;
  localparam logic [19:0] FREQ_MAX   = 20'd1000000;
  localparam logic [19:0] FREQ_RESET = 20'd50000;

  // Ramp lanes: amplitude, frequency and phase run side by side.
  localparam int unsigned LANES   = 3;
  localparam int unsigned LANE_W  = 22;
  localparam int unsigned MAG_W   = 21;
  localparam int unsigned PROD_W  = 53;
  localparam int unsigned DIV_CNT = 21;

  typedef struct packed {
    logic [47:0]        time_v;
    logic [31:0]        len;
    logic [2:0]         chan;
    logic               step;
    logic [2:0]         fields;
    logic signed [12:0] amp;
    logic [19:0]        freq;
    logic signed [19:0] phase;
  } qentry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_DR_RD,
    ST_DR_CHK,
    ST_ADV,
    ST_MUL,
    ST_DIVL,
    ST_DIV,
    ST_APPLY,
    ST_EMIT_CH,
    ST_EMIT_ONE
  } state_e;

endpackage

// ===== hdl/timed_update_queue_with_linear_ramps_unit.sv =====
// ----------------------------------------------------------------------------
// timed_update_queue_with_linear_ramps_unit
// Time-sorted queue of scheduled channel updates with linear ramp engine.
// ----------------------------------------------------------------------------
// The block takes one word at a time. An insert moves every queued entry that
// is later than the new one up by one slot of a circular buffer held in a
// RAM. It reads and compares each entry in turn, which is every moved entry
// plus the earlier entry that ends the search when one remains, then returns
// one result. A clear or unused kind returns one result. A tick reads the
// head entry from the RAM for each due entry until it finds the queue empty
// or its head not yet due, then visits each channel in turn: a channel with
// a running ramp passes through the 21-step serial divider that scales the
// ramp, and each channel gives one result word. Results wait in an output
// register, so a stalled output holds the sequencer.
// ----------------------------------------------------------------------------
module timed_update_queue_with_linear_ramps_unit #(
  parameter int unsigned QUEUE_DEPTH    = 16,
  parameter int unsigned CHANNELS       = 4,
  parameter int unsigned ADC_HALF_RANGE = 2048
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         kind_i,
  input  logic [2:0]         channel_i,
  input  logic [47:0]        apply_time_i,
  input  logic [31:0]        ramp_duration_i,
  input  logic               step_mode_i,
  input  logic [2:0]         field_mask_i,
  input  logic signed [15:0] target_amplitude_i,
  input  logic [19:0]        target_frequency_i,
  input  logic signed [19:0] target_phase_i,
  input  logic [47:0]        now_sample_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               accepted_o,
  output logic [2:0]         out_channel_o,
  output logic signed [12:0] amplitude_o,
  output logic [19:0]        frequency_o,
  output logic signed [19:0] phase_o,
  output logic               ramping_o,
  output logic               last_o
);

  import tuq_pkg::*;

  localparam int unsigned QAW = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CW  = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
  localparam int unsigned EW  = $bits(qentry_t);

  localparam logic signed [15:0] AMP_HI = 16'(ADC_HALF_RANGE);
  localparam logic signed [15:0] AMP_LO = -16'(ADC_HALF_RANGE);

  function automatic logic [QAW-1:0] slot_f(input logic [QAW-1:0] head,
                                            input logic [QAW:0]   idx);
    logic [QAW:0] s;
    s = {1'b0, head} + idx;
    if (s >= (QAW+1)'(QUEUE_DEPTH)) begin
      s = s - (QAW+1)'(QUEUE_DEPTH);
    end
    return s[QAW-1:0];
  endfunction

  function automatic logic signed [LANE_W-1:0] lane_f(
    input int unsigned k, input logic signed [12:0] a,
    input logic [19:0] f, input logic signed [19:0] p);
    logic signed [LANE_W-1:0] v;
    case (k)
      0:       v = LANE_W'(a);
      1:       v = $signed({2'b00, f});
      default: v = LANE_W'(p);
    endcase
    return v;
  endfunction

  state_e state_q, state_d;

  // Control registers
  logic [QAW-1:0] head_q;
  logic [CNW-1:0] count_q, pos_q;
  logic [CW-1:0]  ch_q;
  logic [4:0]     cnt_q;
  logic           res_acc_q;

  // Latched word
  qentry_t     new_q;
  logic [47:0] now_q;

  // Channel state
  logic signed [12:0] cur_amp_q [CHANNELS];
  logic [19:0]        cur_freq_q [CHANNELS];
  logic signed [19:0] cur_ph_q [CHANNELS];
  logic               act_q [CHANNELS];
  logic signed [12:0] st_amp_q [CHANNELS];
  logic [19:0]        st_freq_q [CHANNELS];
  logic signed [19:0] st_ph_q [CHANNELS];
  logic signed [12:0] gl_amp_q [CHANNELS];
  logic [19:0]        gl_freq_q [CHANNELS];
  logic signed [19:0] gl_ph_q [CHANNELS];
  logic [2:0]         rf_q [CHANNELS];
  logic [47:0]        rb_q [CHANNELS];
  logic [31:0]        rl_q [CHANNELS];

  // Ramp datapath
  logic [31:0]              el_q;
  logic [31:0]              dur_q;
  logic                     neg_q [LANES];
  logic [MAG_W-1:0]         mag_q [LANES];
  logic signed [LANE_W-1:0] a_q [LANES];
  logic [PROD_W-1:0]        prod_q [LANES];
  logic [31:0]              rem_q [LANES];
  logic [MAG_W-1:0]         quo_q [LANES];

  // Output register
  logic               out_valid_q;
  logic               accepted_q, ramping_q, last_q;
  logic [2:0]         out_channel_q;
  logic signed [12:0] amplitude_q;
  logic [19:0]        frequency_q;
  logic signed [19:0] phase_q;

  // RAM
  logic           we;
  logic [QAW-1:0] waddr, raddr;
  logic [EW-1:0]  wdata, rdata;
  qentry_t        rd_e;

  tuq_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_e = qentry_t'(rdata);

  logic            accept, ins_ok, out_free, shift, due, last_ch, emit;
  logic [QAW:0]    pos_ext, pos_m1;
  logic [47:0]     el_full;
  logic            ramp_done;
  logic [CW-1:0]   ech;
  qentry_t         ins_e;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = out_free && ((state_q == ST_EMIT_CH) || (state_q == ST_EMIT_ONE));
  assign ins_ok   = (field_mask_i != 3'd0) && ({1'b0, channel_i} < 4'(CHANNELS)) &&
                    (count_q < CNW'(QUEUE_DEPTH));
  assign pos_ext  = (QAW+1)'(pos_q);
  assign pos_m1   = pos_ext - (QAW+1)'(1);
  assign shift    = rd_e.time_v > new_q.time_v;
  assign due      = now_q >= rd_e.time_v;
  assign last_ch  = ch_q == CW'(CHANNELS - 1);
  assign el_full  = now_q - rb_q[ch_q];
  assign ramp_done = (now_q < rb_q[ch_q]) || (el_full >= {16'd0, rl_q[ch_q]});
  assign ech      = rd_e.chan[CW-1:0];

  assign raddr = (state_q == ST_INS_RD) ? slot_f(head_q, pos_m1) : head_q;
  assign we    = (state_q == ST_INS_PUT) || ((state_q == ST_INS_CMP) && shift);
  assign waddr = slot_f(head_q, pos_ext);
  assign wdata = (state_q == ST_INS_PUT) ? EW'(new_q) : rdata;

  // Clamped insert entry.
  always_comb begin
    ins_e        = '0;
    ins_e.time_v = apply_time_i;
    ins_e.len    = ramp_duration_i;
    ins_e.chan   = channel_i;
    ins_e.step   = step_mode_i;
    ins_e.fields = field_mask_i;
    if (target_amplitude_i > AMP_HI) begin
      ins_e.amp = 13'(AMP_HI);
    end else if (target_amplitude_i < AMP_LO) begin
      ins_e.amp = 13'(AMP_LO);
    end else begin
      ins_e.amp = 13'(target_amplitude_i);
    end
    if (target_frequency_i < FREQ_MIN) begin
      ins_e.freq = FREQ_MIN;
    end else if (target_frequency_i > FREQ_MAX) begin
      ins_e.freq = FREQ_MAX;
    end else begin
      ins_e.freq = target_frequency_i;
    end
    ins_e.phase = target_phase_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (kind_i == KIND_TICK) begin
            state_d = ST_DR_RD;
          end else if (kind_i == KIND_INSERT && ins_ok) begin
            state_d = (count_q == '0) ? ST_INS_PUT : ST_INS_RD;
          end else begin
            state_d = ST_EMIT_ONE;
          end
        end
      end
      ST_INS_RD:  state_d = ST_INS_CMP;
      ST_INS_CMP: begin
        if (shift && pos_m1 != '0) begin
          state_d = ST_INS_RD;
        end else begin
          state_d = ST_INS_PUT;
        end
      end
      ST_INS_PUT: state_d = ST_EMIT_ONE;
      ST_DR_RD:   state_d = (count_q == '0) ? ST_ADV : ST_DR_CHK;
      ST_DR_CHK:  state_d = due ? ST_DR_RD : ST_ADV;
      ST_ADV: begin
        if (!act_q[ch_q] || ramp_done) begin
          state_d = ST_EMIT_CH;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:     state_d = ST_DIVL;
      ST_DIVL:    state_d = ST_DIV;
      ST_DIV:     state_d = (cnt_q == 5'(DIV_CNT - 1)) ? ST_APPLY : ST_DIV;
      ST_APPLY:   state_d = ST_EMIT_CH;
      ST_EMIT_CH: begin
        if (out_free) begin
          state_d = last_ch ? ST_IDLE : ST_ADV;
        end
      end
      ST_EMIT_ONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // Control, current values and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      pos_q       <= '0;
      ch_q        <= '0;
      cnt_q       <= '0;
      res_acc_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        cur_amp_q[c]  <= '0;
        cur_freq_q[c] <= FREQ_RESET;
        cur_ph_q[c]   <= '0;
        act_q[c]      <= 1'b0;
      end
    end else begin
      if (out_valid_q && !out_stall_i && !emit) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          ch_q <= '0;
          if (accept) begin
            pos_q     <= count_q;
            res_acc_q <= (kind_i == KIND_CLEAR);
            if (kind_i == KIND_CLEAR) begin
              count_q   <= '0;
              for (int c = 0; c < CHANNELS; c++) begin
                act_q[c] <= 1'b0;
              end
            end
          end
        end
        ST_INS_CMP: begin
          if (shift) begin
            pos_q <= pos_q - CNW'(1);
          end
        end
        ST_INS_PUT: begin
          count_q   <= count_q + CNW'(1);
          res_acc_q <= 1'b1;
        end
        ST_DR_CHK: begin
          if (due) begin
            head_q  <= (head_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_q + QAW'(1);
            count_q <= count_q - CNW'(1);
            if (rd_e.step || rd_e.len == '0) begin
              if (rd_e.fields[0]) cur_amp_q[ech]  <= rd_e.amp;
              if (rd_e.fields[1]) cur_freq_q[ech] <= rd_e.freq;
              if (rd_e.fields[2]) cur_ph_q[ech]   <= rd_e.phase;
              act_q[ech] <= 1'b0;
            end else begin
              act_q[ech] <= 1'b1;
            end
          end
        end
        ST_ADV: begin
          if (act_q[ch_q] && ramp_done) begin
            if (rf_q[ch_q][0]) cur_amp_q[ch_q]  <= gl_amp_q[ch_q];
            if (rf_q[ch_q][1]) cur_freq_q[ch_q] <= gl_freq_q[ch_q];
            if (rf_q[ch_q][2]) cur_ph_q[ch_q]   <= gl_ph_q[ch_q];
            act_q[ch_q] <= 1'b0;
          end
        end
        ST_DIVL: cnt_q <= '0;
        ST_DIV:  cnt_q <= cnt_q + 5'd1;
        ST_APPLY: begin
          for (int k = 0; k < LANES; k++) begin
            logic signed [LANE_W-1:0] q, r;
            q = $signed({1'b0, quo_q[k]});
            r = a_q[k] + (neg_q[k] ? -q : q);
            if (rf_q[ch_q][k]) begin
              case (k)
                0:       cur_amp_q[ch_q]  <= 13'(r);
                1:       cur_freq_q[ch_q] <= 20'(r);
                default: cur_ph_q[ch_q]   <= 20'(r);
              endcase
            end
          end
        end
        ST_EMIT_CH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            ch_q        <= ch_q + CW'(1);
          end
        end
        ST_EMIT_ONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers: latched word, ramp records, divider and output data.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          new_q <= ins_e;
          now_q <= now_sample_i;
        end
      end
      ST_DR_CHK: begin
        if (due && !(rd_e.step || rd_e.len == '0)) begin
          st_amp_q[ech]  <= cur_amp_q[ech];
          st_freq_q[ech] <= cur_freq_q[ech];
          st_ph_q[ech]   <= cur_ph_q[ech];
          gl_amp_q[ech]  <= rd_e.fields[0] ? rd_e.amp : cur_amp_q[ech];
          gl_freq_q[ech] <= rd_e.fields[1] ? rd_e.freq : cur_freq_q[ech];
          gl_ph_q[ech]   <= rd_e.fields[2] ? rd_e.phase : cur_ph_q[ech];
          rf_q[ech]      <= rd_e.fields;
          rb_q[ech]      <= rd_e.time_v;
          rl_q[ech]      <= rd_e.len;
        end
      end
      ST_ADV: begin
        el_q  <= el_full[31:0];
        dur_q <= rl_q[ch_q];
        for (int k = 0; k < LANES; k++) begin
          logic signed [LANE_W-1:0] a, b, d;
          a = lane_f(k, st_amp_q[ch_q], st_freq_q[ch_q], st_ph_q[ch_q]);
          b = lane_f(k, gl_amp_q[ch_q], gl_freq_q[ch_q], gl_ph_q[ch_q]);
          d = b - a;
          a_q[k]   <= a;
          neg_q[k] <= d[LANE_W-1];
          mag_q[k] <= d[LANE_W-1] ? MAG_W'(-d) : MAG_W'(d);
        end
      end
      ST_MUL: begin
        for (int k = 0; k < LANES; k++) begin
          prod_q[k] <= PROD_W'(mag_q[k]) * PROD_W'(el_q);
        end
      end
      ST_DIVL: begin
        // The quotient stays below 2^21, so the upper bits are below the divisor.
        for (int k = 0; k < LANES; k++) begin
          rem_q[k] <= prod_q[k][PROD_W-1:MAG_W];
          quo_q[k] <= prod_q[k][MAG_W-1:0];
        end
      end
      ST_DIV: begin
        for (int k = 0; k < LANES; k++) begin
          logic [32:0] r2;
          r2 = {rem_q[k], quo_q[k][MAG_W-1]};
          if (r2 >= {1'b0, dur_q}) begin
            rem_q[k] <= 32'(r2 - {1'b0, dur_q});
            quo_q[k] <= {quo_q[k][MAG_W-2:0], 1'b1};
          end else begin
            rem_q[k] <= r2[31:0];
            quo_q[k] <= {quo_q[k][MAG_W-2:0], 1'b0};
          end
        end
      end
      ST_EMIT_CH: begin
        if (out_free) begin
          accepted_q    <= 1'b1;
          out_channel_q <= 3'(ch_q);
          amplitude_q   <= cur_amp_q[ch_q];
          frequency_q   <= cur_freq_q[ch_q];
          phase_q       <= cur_ph_q[ch_q];
          ramping_q     <= act_q[ch_q];
          last_q        <= last_ch;
        end
      end
      ST_EMIT_ONE: begin
        if (out_free) begin
          accepted_q    <= res_acc_q;
          out_channel_q <= '0;
          amplitude_q   <= '0;
          frequency_q   <= '0;
          phase_q       <= '0;
          ramping_q     <= 1'b0;
          last_q        <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign accepted_o    = accepted_q;
  assign out_channel_o = out_channel_q;
  assign amplitude_o   = amplitude_q;
  assign frequency_o   = frequency_q;
  assign phase_o       = phase_q;
  assign ramping_o     = ramping_q;
  assign last_o        = last_q;

endmodule

// ===== hdl/tuq_ram.sv =====
// ----------------------------------------------------------------------------
// tuq_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module tuq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
